### design/ins_sort_pkg.sv
// ---------------------------------------------------------------------------
// ins_sort_pkg
// Shared constants and types for the insertion sorter cell chain.
// ---------------------------------------------------------------------------
`default_nettype none

package ins_sort_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  // per-cycle command broadcast to every cell
  localparam logic [1:0] CMD_HOLD   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_SHIFT  = 2'd2;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### design/ins_sort_cell.sv
// ---------------------------------------------------------------------------
// ins_sort_cell
// One slot of the sorted chain: compares against the broadcast value and
// takes it at the insertion point, takes its lower neighbor's entry when that
// one moves up, or its upper neighbor's entry while the set drains.
// ---------------------------------------------------------------------------
`default_nettype none

module ins_sort_cell
  import ins_sort_pkg::*;
(
  input  wire logic                     clk,
  input  wire cell_ctrl_t               ctrl,
  input  wire logic                     occupied,
  input  wire logic                     prev_gt,
  input  wire logic signed [DATA_W-1:0] prev_val,
  input  wire logic signed [DATA_W-1:0] next_val,
  output logic                          gt,
  output logic signed [DATA_W-1:0]      val
);

  logic signed [DATA_W-1:0] val_next;

  // strictly greater entries move up, so equal values keep arrival order
  assign gt = occupied && (val > ctrl.value);

  always_comb begin
    val_next = val;
    unique case (ctrl.cmd)
      CMD_INSERT: begin
        if (prev_gt) begin
          val_next = prev_val;
        end else if (gt || !occupied) begin
          val_next = ctrl.value;
        end
      end
      CMD_SHIFT: val_next = next_val;
      default:   val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

`default_nettype wire

### design/insertion_sorter_core.sv
// ---------------------------------------------------------------------------
// insertion_sorter_core
// Stable insertion sorter built as a chain of compare-and-shift cells.
// ---------------------------------------------------------------------------
// Values enter one per cycle while the set is filling; every cell compares
// against the new value at once and larger entries move up one slot in the
// same cycle. The item marked last_item ends the set: input is then held
// off while the set drains from the bottom cell, one result per cycle while
// out_ready is high; the chain keeps up to MAX_ITEMS values per set.
// Values arriving into a full chain are dropped and every result of that
// set carries overflowed.
`default_nettype none

module insertion_sorter_core
  import ins_sort_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire logic                     last_item,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DATA_W-1:0]      sorted_value,
  output logic                          last_result,
  output logic                          overflowed
);

  localparam logic ST_FILL  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic             state, state_next;
  logic [CNT_W-1:0] fill_count, fill_count_next;
  logic             overflow_flag, overflow_flag_next;

  logic       in_acc, out_acc, full;
  cell_ctrl_t ctrl;

  logic                     gt  [MAX_ITEMS];
  logic signed [DATA_W-1:0] val [MAX_ITEMS];

  assign in_ready = (state == ST_FILL);
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign full     = (fill_count == CNT_W'(MAX_ITEMS));

  assign out_valid    = (state == ST_DRAIN);
  assign sorted_value = val[0];
  assign last_result  = (fill_count == CNT_W'(1));
  assign overflowed   = overflow_flag;

  always_comb begin
    ctrl.value = value;
    if (in_acc && !full) begin
      ctrl.cmd = CMD_INSERT;
    end else if (out_acc) begin
      ctrl.cmd = CMD_SHIFT;
    end else begin
      ctrl.cmd = CMD_HOLD;
    end
  end

  always_comb begin
    state_next         = state;
    fill_count_next    = fill_count;
    overflow_flag_next = overflow_flag;
    unique case (state)
      ST_FILL: begin
        if (in_acc) begin
          if (full) begin
            overflow_flag_next = 1'b1;
          end else begin
            fill_count_next = fill_count + CNT_W'(1);
          end
          if (last_item) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_acc) begin
          fill_count_next = fill_count - CNT_W'(1);
          if (last_result) begin
            state_next         = ST_FILL;
            overflow_flag_next = 1'b0;
          end
        end
      end
      default: state_next = ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_FILL;
      fill_count    <= '0;
      overflow_flag <= 1'b0;
    end else begin
      state         <= state_next;
      fill_count    <= fill_count_next;
      overflow_flag <= overflow_flag_next;
    end
  end

  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    logic                     occ;
    logic                     p_gt;
    logic signed [DATA_W-1:0] p_val;
    logic signed [DATA_W-1:0] n_val;

    assign occ = (CNT_W'(k) < fill_count);

    if (k == 0) begin : g_first
      assign p_gt  = 1'b0;
      assign p_val = '0;
    end else begin : g_mid
      assign p_gt  = gt[k-1];
      assign p_val = val[k-1];
    end

    if (k == MAX_ITEMS - 1) begin : g_top
      assign n_val = val[k];
    end else begin : g_below
      assign n_val = val[k+1];
    end

    ins_sort_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occupied (occ),
      .prev_gt  (p_gt),
      .prev_val (p_val),
      .next_val (n_val),
      .gt       (gt[k]),
      .val      (val[k])
    );
  end

endmodule

`default_nettype wire

### tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for insertion_sorter_core: value sets go in over a
// valid/ready channel, and each sorted set coming back is compared field by
// field against a software insertion sort. Traffic runs through four idling
// phases, each with a store-sized set: full in the first, overflowing after.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ins_sort_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 105;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } set_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     ovf;
  } sorted_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] value = '0;
  logic                     last_item = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     last_result;
  logic                     overflowed;

  insertion_sorter_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .value        (value),
    .last_item    (last_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sorted_value (sorted_value),
    .last_result  (last_result),
    .overflowed   (overflowed)
  );

  set_item_t      pending_items[$];
  sorted_result_t sorted_expect[$];
  set_item_t      next_item;
  sorted_result_t want;
  idle_mode_t     idle_mode = IDLE_NONE;

  // software copy of the sorter state
  logic signed [DATA_W-1:0] shadow_store[MAX_ITEMS];
  int                       shadow_fill = 0;
  bit                       shadow_ovf = 1'b0;

  logic in_taken = 1'b0;
  int   quiet_cycles = 0;
  int   items_queued = 0;
  int   items_accepted = 0;
  int   results_seen = 0;
  int   sets_sorted = 0;
  int   sets_overflowed = 0;
  int   error_count = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic signed [DATA_W-1:0] exp_v,
                                 input logic signed [DATA_W-1:0] got_v);
    $display("%0t ns: mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
    error_count++;
  endtask

  // stable insertion: only strictly greater entries move up
  function automatic void sort_insert(input logic signed [DATA_W-1:0] v, input logic last);
    int             pos;
    sorted_result_t r;
    if (shadow_fill < MAX_ITEMS) begin
      pos = shadow_fill;
      while (pos > 0 && shadow_store[pos-1] > v) begin
        shadow_store[pos] = shadow_store[pos-1];
        pos--;
      end
      shadow_store[pos] = v;
      shadow_fill++;
    end else begin
      shadow_ovf = 1'b1;
    end
    if (last) begin
      for (int k = 0; k < shadow_fill; k++) begin
        r.value = shadow_store[k];
        r.last  = (k + 1 == shadow_fill);
        r.ovf   = shadow_ovf;
        sorted_expect.push_back(r);
      end
      sets_sorted++;
      if (shadow_ovf) sets_overflowed++;
      shadow_fill = 0;
      shadow_ovf  = 1'b0;
    end
  endfunction

  function automatic int send_idle_pct();
    return (idle_mode == IDLE_SEND) ? 55 : (idle_mode == IDLE_BOTH) ? 36 : 0;
  endfunction

  function automatic int recv_stall_pct();
    return (idle_mode == IDLE_RECV) ? 55 : (idle_mode == IDLE_BOTH) ? 36 : 0;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5:       return int'($urandom_range(20)) - 10;  // many duplicates
      6: begin
        case ($urandom_range(5))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7fff_ffff;
          2:       return 32'sh0000_0000;
          3:       return 32'shffff_ffff;
          4:       return 32'sh8000_0001;
          default: return 32'sh7fff_fffe;
        endcase
      end
      default:    return $urandom >>> $urandom_range(31);
    endcase
  endfunction

  task automatic push_item(input logic signed [DATA_W-1:0] v, input logic last);
    set_item_t it;
    it.value = v;
    it.last  = last;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_set(input int n);
    for (int i = 0; i < n; i++) push_item(pick_value(), i == n - 1);
  endtask

  task automatic wait_drained();
    while (items_accepted != items_queued || sorted_expect.size() != 0) @(negedge clk);
  endtask

  // driver: payload moves at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
          next_item = pending_items.pop_front();
          in_valid  <= 1'b1;
          value     <= next_item.value;
          last_item <= next_item.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct());
    end
  end

  // monitor: predict on input accept, check on output accept
  always @(posedge clk) begin
    if (rst) begin
      in_taken     <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        sort_insert(value, last_item);
        items_accepted++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (sorted_expect.size() == 0) begin
          report_mismatch("result with nothing expected", 0, sorted_value);
        end else begin
          want = sorted_expect.pop_front();
          if (sorted_value !== want.value)
            report_mismatch("sorted_value", want.value, sorted_value);
          if (last_result !== want.last)
            report_mismatch("last_result", want.last, last_result);
          if (overflowed !== want.ovf)
            report_mismatch("overflowed", want.ovf, overflowed);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int phase_start;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed sets: single extremes, full-range mix, reversed, duplicates, sorted
    push_item(32'sh8000_0000, 1'b1);
    push_item(32'sh7fff_ffff, 1'b1);
    push_item(0, 1'b0);
    push_item(-1, 1'b0);
    push_item(1, 1'b0);
    push_item(32'sh7fff_ffff, 1'b0);
    push_item(32'sh8000_0000, 1'b0);
    push_item(32'sh8000_0001, 1'b0);
    push_item(32'sh7fff_fffe, 1'b1);
    for (int i = 5; i >= 1; i--) push_item(i, i == 1);
    push_item(7, 1'b0);
    push_item(-3, 1'b0);
    push_item(7, 1'b0);
    push_item(-3, 1'b0);
    push_item(7, 1'b0);
    push_item(0, 1'b1);
    push_item(-2, 1'b0);
    push_item(-1, 1'b0);
    push_item(0, 1'b1);

    for (int p = 0; p < 4; p++) begin
      idle_mode = idle_mode_t'(p);
      phase_start = items_queued;
      // one store-sized set per phase: exactly full, then one to three dropped
      queue_set(MAX_ITEMS + p);
      while (items_queued - phase_start < ITEMS_PER_PHASE) begin
        if ($urandom_range(4) == 0) queue_set($urandom_range(9, 30));
        else                        queue_set($urandom_range(1, 8));
      end
      wait_drained();
    end

    repeat (2 * MAX_ITEMS + 16) @(negedge clk);
    $display("Sorted %0d sets: %0d items in, %0d results out, %0d sets overflowed the store.",
             sets_sorted, items_accepted, results_seen, sets_overflowed);
    $display("Idling phases run: none, sender 55%%, receiver 55%%, both 36%%.");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
design/ins_sort_pkg.sv
design/ins_sort_cell.sv
design/insertion_sorter_core.sv
tb/tb_top.sv
